### sv/bblc_pkg.sv
// ----------------------------------------------------------------------------
// bblc_pkg
// Shared types and constants for the byte-budget LRU cache table.
// ----------------------------------------------------------------------------
package bblc_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 16;
    localparam int unsigned TAG_BITS_DEF    = 32;
    localparam logic [31:0] CAP_RESET       = 32'd1073741824;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_ERASE = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FOUND,
        ST_DROP,
        ST_DECIDE,
        ST_OLDEST,
        ST_EVICT,
        ST_FREE,
        ST_INSERT,
        ST_TOUCH,
        ST_DONE
    } t_state;

endpackage

### sv/bblc_req_if.sv
// ----------------------------------------------------------------------------
// bblc_req_if
// Request channel: opcode, key tag and object size.
// ----------------------------------------------------------------------------
interface bblc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] key_tag;
    logic [31:0] object_bytes;

    modport source (output valid, opcode, key_tag, object_bytes, input ready);
    modport sink (input valid, opcode, key_tag, object_bytes, output ready);
endinterface

### sv/bblc_rsp_if.sv
// ----------------------------------------------------------------------------
// bblc_rsp_if
// Result channel of the cache table.
// ----------------------------------------------------------------------------
interface bblc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        accepted;
    logic [3:0]  slot;
    logic [4:0]  evicted_count;
    logic [31:0] resident_total;
    logic [4:0]  entry_count;
    logic [31:0] hit_total;
    logic [31:0] miss_total;

    modport source (output valid, hit, accepted, slot, evicted_count, resident_total,
                    entry_count, hit_total, miss_total, input ready);
    modport sink (input valid, hit, accepted, slot, evicted_count, resident_total,
                  entry_count, hit_total, miss_total, output ready);
endinterface

### sv/byte_budget_lru_cache.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache
// LRU table of tagged objects under a byte budget, scanned one entry a cycle.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Beat
// i_req     in   valid/ready      opcode, key_tag, object_bytes
// o_rsp     out  valid/ready      hit, accepted, slot, counts and totals
// apb       in   psel/penable     byte budget register at address 0
//
// One request is taken at a time. Each pass over the table steps through the
// entries one at a time. A get or erase takes a search pass and, on a match,
// a rank or removal pass. A put takes a search pass, a removal pass for a
// same-tag entry, two passes per eviction and, if the object fits the budget,
// a free-slot pass and a rank pass. A clear takes no pass. The result is held
// in an output register until taken, and no request is taken while it waits.
// Reset is synchronous and clears the table.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache
    import bblc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bblc_req_if.sink    i_req,
    bblc_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

    logic [31:0]       r_cap;
    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    logic [TAG_BITS-1:0] r_tag  [MAX_ENTRIES];
    logic [31:0]       r_size [MAX_ENTRIES];
    logic [IW-1:0]     r_rank [MAX_ENTRIES];

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx;
    logic [1:0]        r_op;
    logic [TAG_BITS-1:0] r_key;
    logic [31:0]       r_bytes;
    logic              r_found;
    logic [IW-1:0]     r_sel;
    logic [IW-1:0]     r_selrank;
    logic [31:0]       r_sum;
    logic [CW-1:0]     r_cnt;
    logic [31:0]       r_hits, r_miss;
    logic [CW-1:0]     r_evict;
    logic              r_ovalid;
    logic              r_hit, r_acc;
    logic [IW-1:0]     r_slot;

    logic [TAG_BITS-1:0] w_key;
    logic [32:0]       w_add;
    logic              w_fit;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? r_cap : 32'd0;
    assign w_key  = TAG_BITS'(i_req.key_tag);
    assign w_add  = {1'b0, r_sum} + {1'b0, r_bytes};
    assign w_fit  = r_sum <= (r_cap - r_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_cap <= pwdata;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_req.valid && !r_ovalid) begin
                n_state = (t_op'(i_req.opcode) == OP_CLEAR) ? ST_DONE : ST_FIND;
            end
            ST_FIND:   if (r_idx == LAST || (r_valid[r_idx] && r_tag[r_idx] == r_key)) begin
                n_state = ST_FOUND;
            end
            ST_FOUND: begin
                if (!r_found) begin
                    n_state = (t_op'(r_op) == OP_PUT) ? ST_DECIDE : ST_DONE;
                end else if (t_op'(r_op) == OP_GET) begin
                    n_state = ST_TOUCH;
                end else begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP:   if (r_idx == LAST) begin
                n_state = (t_op'(r_op) == OP_PUT) ? ST_DECIDE : ST_DONE;
            end
            ST_DECIDE: begin
                if (r_bytes > r_cap) begin
                    n_state = ST_DONE;
                end else if (r_cnt != '0 && (!w_fit || r_cnt == CW'(MAX_ENTRIES))) begin
                    n_state = ST_OLDEST;
                end else begin
                    n_state = ST_FREE;
                end
            end
            ST_OLDEST: if (r_idx == LAST) begin
                n_state = ST_EVICT;
            end
            ST_EVICT:  if (r_idx == LAST) begin
                n_state = ST_DECIDE;
            end
            ST_FREE:   if (!r_valid[r_idx]) begin
                n_state = ST_INSERT;
            end
            ST_INSERT: if (r_idx == LAST) begin
                n_state = ST_DONE;
            end
            ST_TOUCH:  if (r_idx == LAST) begin
                n_state = ST_DONE;
            end
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = i_rst_n && (r_state == ST_IDLE) && !r_ovalid;
        n_valid     = r_valid;
        if (r_state == ST_IDLE && i_req.valid && !r_ovalid
            && t_op'(i_req.opcode) == OP_CLEAR) begin
            n_valid = '0;
        end else if ((r_state == ST_DROP || r_state == ST_EVICT) && r_idx == LAST) begin
            n_valid[r_sel] = 1'b0;
        end else if (r_state == ST_FREE && !r_valid[r_idx]) begin
            n_valid[r_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (i_req.valid && !r_ovalid) begin
                        if (t_op'(i_req.opcode) == OP_CLEAR) begin
                            r_sum <= '0;
                            r_cnt <= '0;
                        end
                    end
                end
                ST_FIND: begin
                    if (r_valid[r_idx] && r_tag[r_idx] == r_key) begin
                        r_idx <= '0;
                    end else if (r_idx != LAST) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx <= '0;
                    end
                end
                ST_FOUND: begin
                    r_idx <= '0;
                    if (t_op'(r_op) == OP_GET && r_found) begin
                        if (r_hits != '1) r_hits <= r_hits + 1'b1;
                    end else if (t_op'(r_op) == OP_GET) begin
                        if (r_miss != '1) r_miss <= r_miss + 1'b1;
                    end
                end
                ST_DROP, ST_EVICT: begin
                    if (r_idx == LAST) begin
                        r_idx <= '0;
                        r_sum <= (r_sum >= r_size[r_sel]) ? r_sum - r_size[r_sel] : '0;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DECIDE: r_idx <= '0;
                ST_OLDEST: begin
                    r_idx <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
                end
                ST_FREE: begin
                    if (!r_valid[r_idx]) begin
                        r_idx <= '0;
                        r_sum <= w_add[32] ? '1 : w_add[31:0];
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_INSERT, ST_TOUCH: begin
                    r_idx <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
                end
                ST_DONE: r_ovalid <= 1'b1;
                default: r_idx <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && !r_ovalid) begin
                    r_op    <= i_req.opcode;
                    r_key   <= w_key;
                    r_bytes <= i_req.object_bytes;
                    r_found <= 1'b0;
                    r_evict <= '0;
                    r_hit   <= 1'b0;
                    r_acc   <= 1'b0;
                    r_slot  <= '0;
                end
            end
            ST_FIND: begin
                if (r_valid[r_idx] && r_tag[r_idx] == r_key) begin
                    r_found   <= 1'b1;
                    r_sel     <= r_idx;
                    r_selrank <= r_rank[r_idx];
                end
            end
            ST_FOUND: begin
                if (t_op'(r_op) == OP_GET && r_found) begin
                    r_hit  <= 1'b1;
                    r_slot <= r_sel;
                end
            end
            ST_DROP: begin
                if (r_valid[r_idx] && r_rank[r_idx] > r_selrank) begin
                    r_rank[r_idx] <= r_rank[r_idx] - 1'b1;
                end
            end
            ST_DECIDE: r_found <= 1'b0;
            ST_OLDEST: begin
                if (r_valid[r_idx] && (!r_found || r_rank[r_idx] > r_selrank)) begin
                    r_found   <= 1'b1;
                    r_sel     <= r_idx;
                    r_selrank <= r_rank[r_idx];
                end
            end
            ST_EVICT: begin
                if (r_valid[r_idx] && r_rank[r_idx] > r_selrank) begin
                    r_rank[r_idx] <= r_rank[r_idx] - 1'b1;
                end
                if (r_idx == LAST) r_evict <= r_evict + 1'b1;
            end
            ST_FREE: begin
                if (!r_valid[r_idx]) begin
                    r_tag[r_idx]  <= r_key;
                    r_size[r_idx] <= r_bytes;
                    r_sel         <= r_idx;
                    r_acc         <= 1'b1;
                    r_slot        <= r_idx;
                end
            end
            ST_INSERT: begin
                if (r_idx == r_sel) begin
                    r_rank[r_idx] <= '0;
                end else if (r_valid[r_idx]) begin
                    r_rank[r_idx] <= r_rank[r_idx] + 1'b1;
                end
            end
            ST_TOUCH: begin
                if (r_idx == r_sel) begin
                    r_rank[r_idx] <= '0;
                end else if (r_valid[r_idx] && r_rank[r_idx] < r_selrank) begin
                    r_rank[r_idx] <= r_rank[r_idx] + 1'b1;
                end
            end
            default: r_found <= r_found;
        endcase
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.hit            = r_hit;
    assign o_rsp.accepted       = r_acc;
    assign o_rsp.slot           = 4'(r_slot);
    assign o_rsp.evicted_count  = 5'(r_evict);
    assign o_rsp.resident_total = r_sum;
    assign o_rsp.entry_count    = 5'(r_cnt);
    assign o_rsp.hit_total      = r_hits;
    assign o_rsp.miss_total     = r_miss;

endmodule

### tb/byte_budget_lru_cache_chk.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_chk
// Watches the request, result and register ports of the cache table, keeps
// its own LRU table to predict every result beat, and compares the beats
// that come back, field by field, in order.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_chk
    import bblc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bblc_req_if         req,
    bblc_rsp_if         rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic        hit;
        logic        accepted;
        logic [3:0]  slot;
        logic [4:0]  evicted_count;
        logic [31:0] resident_total;
        logic [4:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_result;

    logic        ent_vld  [SLOTS];
    logic [31:0] ent_tag  [SLOTS];
    logic [31:0] ent_size [SLOTS];
    int unsigned ent_rank [SLOTS];
    logic [31:0] cap_bytes;
    logic [31:0] bytes_held;
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;
    int unsigned used;
    t_result     expected_results[$];

    assign o_pending = expected_results.size();

    function automatic int lookup_slot(logic [31:0] tag);
        for (int i = 0; i < SLOTS; i++) begin
            if (ent_vld[i] && ent_tag[i] == tag) return i;
        end
        return -1;
    endfunction

    function automatic int lru_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (ent_vld[i] && (best < 0 || ent_rank[i] > ent_rank[best])) best = i;
        end
        return best;
    endfunction

    function automatic void remove_slot(int s);
        int unsigned r;
        r = ent_rank[s];
        ent_vld[s] = 1'b0;
        bytes_held = (bytes_held >= ent_size[s]) ? bytes_held - ent_size[s] : 32'd0;
        if (used > 0) used--;
        for (int i = 0; i < SLOTS; i++) begin
            if (ent_vld[i] && ent_rank[i] > r) ent_rank[i]--;
        end
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < SLOTS; i++) ent_vld[i] = 1'b0;
        bytes_held = '0;
        used = 0;
    endfunction

    function automatic t_result cache_access(t_op op, logic [31:0] tag, logic [31:0] nbytes);
        t_result     res;
        int          s;
        int unsigned r;
        logic [32:0] total;
        res = '0;
        case (op)
            OP_GET: begin
                s = lookup_slot(tag);
                if (s >= 0) begin
                    res.hit = 1'b1;
                    res.slot = s[3:0];
                    r = ent_rank[s];
                    for (int i = 0; i < SLOTS; i++) begin
                        if (ent_vld[i] && ent_rank[i] < r) ent_rank[i]++;
                    end
                    ent_rank[s] = 0;
                    if (hit_cnt != '1) hit_cnt++;
                end else if (miss_cnt != '1) begin
                    miss_cnt++;
                end
            end
            OP_PUT: begin
                s = lookup_slot(tag);
                if (s >= 0) remove_slot(s);
                if (nbytes <= cap_bytes) begin
                    while (used > 0 && bytes_held > cap_bytes - nbytes) begin
                        s = lru_slot();
                        if (s < 0) break;
                        remove_slot(s);
                        res.evicted_count++;
                    end
                    if (used >= SLOTS) begin
                        s = lru_slot();
                        if (s >= 0) begin
                            remove_slot(s);
                            res.evicted_count++;
                        end
                    end
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!ent_vld[i]) s = i;
                    end
                    if (s >= 0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (ent_vld[i]) ent_rank[i]++;
                        end
                        ent_vld[s] = 1'b1;
                        ent_tag[s] = tag;
                        ent_size[s] = nbytes;
                        ent_rank[s] = 0;
                        used++;
                        total = {1'b0, bytes_held} + {1'b0, nbytes};
                        bytes_held = total[32] ? 32'hFFFF_FFFF : total[31:0];
                        res.accepted = 1'b1;
                        res.slot = s[3:0];
                    end
                end
            end
            OP_ERASE: begin
                s = lookup_slot(tag);
                if (s >= 0) remove_slot(s);
            end
            default: empty_table();
        endcase
        res.resident_total = bytes_held;
        res.entry_count = used[4:0];
        res.hit_total = hit_cnt;
        res.miss_total = miss_cnt;
        return res;
    endfunction

    function automatic void compare_beat(t_result exp_r, t_result act);
        if (act.hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, act.hit);
            o_fail_count++;
        end
        if (act.accepted !== exp_r.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_r.accepted, act.accepted);
            o_fail_count++;
        end
        if (act.slot !== exp_r.slot) begin
            $error("slot: expected %0d, got %0d", exp_r.slot, act.slot);
            o_fail_count++;
        end
        if (act.evicted_count !== exp_r.evicted_count) begin
            $error("evicted_count: expected %0d, got %0d", exp_r.evicted_count,
                   act.evicted_count);
            o_fail_count++;
        end
        if (act.resident_total !== exp_r.resident_total) begin
            $error("resident_total: expected %0d, got %0d", exp_r.resident_total,
                   act.resident_total);
            o_fail_count++;
        end
        if (act.entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, act.entry_count);
            o_fail_count++;
        end
        if (act.hit_total !== exp_r.hit_total) begin
            $error("hit_total: expected %0d, got %0d", exp_r.hit_total, act.hit_total);
            o_fail_count++;
        end
        if (act.miss_total !== exp_r.miss_total) begin
            $error("miss_total: expected %0d, got %0d", exp_r.miss_total, act.miss_total);
            o_fail_count++;
        end
    endfunction

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_result act;
        if (!i_rst_n) begin
            empty_table();
            cap_bytes = CAP_RESET;
            hit_cnt = '0;
            miss_cnt = '0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0) cap_bytes = pwdata;
            if (rsp.valid && rsp.ready) begin
                act = '{rsp.hit, rsp.accepted, rsp.slot, rsp.evicted_count,
                        rsp.resident_total, rsp.entry_count, rsp.hit_total, rsp.miss_total};
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_fail_count++;
                end else begin
                    compare_beat(expected_results.pop_front(), act);
                end
            end
            if (req.valid && req.ready) begin
                expected_results.push_back(
                    cache_access(t_op'(req.opcode), req.key_tag, req.object_bytes));
            end
        end
    end

endmodule

### tb/byte_budget_lru_cache_tb.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_tb
// Drives directed and random get, put, erase and clear requests through the
// cache table over several byte budgets, with random gaps and result stalls;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_tb;
    import bblc_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int TAG_POOL = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          quiet;
    logic [31:0] cap_now;
    logic [31:0] tag_pool [TAG_POOL];

    bblc_req_if req ();
    bblc_rsp_if rsp ();

    byte_budget_lru_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    byte_budget_lru_cache_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[byte_budget_lru_cache] ERROR");
            $finish;
        end
    end

    // Result side: a random stall before each beat, none in quiet stretches.
    initial begin
        int stall;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                rsp.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            rsp.ready = 1'b1;
            do @(posedge i_clk); while (!rsp.valid);
        end
    end

    task automatic send_request(t_op op, logic [31:0] tag, logic [31:0] nbytes);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            req.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req.opcode = op;
        req.key_tag = tag;
        req.object_bytes = nbytes;
        req.valid = 1'b1;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [31:0] value);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 2'd0;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cap_now = value;
    endtask

    function automatic logic [31:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return (cap_now < 32'd64) ? $urandom_range(0, cap_now)
                                                 : $urandom_range(0, cap_now / 5);
        if (roll < 76) return cap_now;
        if (roll < 82) return cap_now + 32'd1;
        if (roll < 88) return 32'd0;
        if (roll < 94) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic random_phase(int count);
        int unsigned roll;
        logic [31:0] tag;
        for (int k = 0; k < TAG_POOL; k++) tag_pool[k] = $urandom();
        tag_pool[0] = 32'd0;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            tag = ($urandom_range(0, 9) == 0) ? $urandom()
                                              : tag_pool[$urandom_range(0, TAG_POOL - 1)];
            if (roll < 40) send_request(OP_GET, tag, $urandom());
            else if (roll < 82) send_request(OP_PUT, tag, pick_size());
            else if (roll < 97) send_request(OP_ERASE, tag, $urandom());
            else send_request(OP_CLEAR, $urandom(), $urandom());
        end
        quiet = 1'b0;
    endtask

    initial begin
        quiet = 1'b0;
        cap_now = CAP_RESET;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 2'd0;
        pwdata = '0;
        req.valid = 1'b0;
        req.opcode = OP_GET;
        req.key_tag = '0;
        req.object_bytes = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: misses, zero-size and exact-fit puts, oversize put that
        // still drops the same tag, same-tag replacement, full-table eviction,
        // erase of present and absent tags, and clear.
        send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'd0, 32'd0);
        send_request(OP_GET, 32'd0, 32'd0);
        send_request(OP_PUT, 32'h5A5A_5A5A, CAP_RESET);
        send_request(OP_PUT, 32'h5A5A_5A5A, CAP_RESET + 32'd1);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'h1234_5678, 32'd100);
        send_request(OP_PUT, 32'h1234_5678, 32'd300);
        for (int k = 0; k < 17; k++) send_request(OP_PUT, 32'h100 + k, 32'd10);
        send_request(OP_GET, 32'h101, 32'd0);
        send_request(OP_ERASE, 32'h105, 32'd0);
        send_request(OP_ERASE, 32'hDEAD_BEEF, 32'd0);
        send_request(OP_CLEAR, 32'd0, 32'd0);
        send_request(OP_GET, 32'h101, 32'd0);

        random_phase(300);
        write_capacity(32'd1000);
        random_phase(300);
        write_capacity(32'd0);
        random_phase(150);
        write_capacity(32'hFFFF_FFFF);
        random_phase(300);
        write_capacity(32'd60);
        random_phase(250);
        write_capacity($urandom());
        random_phase(250);
        write_capacity(32'd100000);
        random_phase(250);

        drain();
        repeat (400) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[byte_budget_lru_cache] OK");
        end else begin
            $display("[byte_budget_lru_cache] ERROR");
        end
        $finish;
    end

endmodule
